[rtl/assert_macros.svh]
// Assertion macros shared by the smoother RTL.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checks a property under reset disable.
`define AWS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Checks that the consequent holds in the same cycle as the antecedent.
`define AWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define AWS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define AWS_ASSERT(lbl, clk, rstn, prop, msg)
`define AWS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define AWS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

[rtl/aws_pkg.sv]
// Package of the adaptive weighted smoother: default width and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package aws_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_a;
    logic mul_b;
    logic sum;
    logic div_init;
    logic div_step;
    logic commit;
  } aws_cmd_t;

  typedef struct packed {
    logic first;
    logic div_last;
  } aws_sts_t;

endpackage

[rtl/aws_if.sv]
// Valid/ready stream interfaces for the smoother's input and output words.
// Depends on aws_pkg for the default sample width.
`timescale 1ns / 1ps

interface aws_in_if #(parameter int W = aws_pkg::SAMPLE_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;
  logic                first;

  modport source (output valid, output sample, output first, input ready);
  modport sink   (input valid, input sample, input first, output ready);
endinterface

interface aws_out_if #(parameter int W = aws_pkg::SAMPLE_BITS_DEF) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] smoothed;

  modport source (output valid, output smoothed, input ready);
  modport sink   (input valid, input smoothed, output ready);
endinterface

[rtl/adaptive_weighted_smoother_top.sv]
// Top level of the adaptive weighted smoother: controller, datapath and
// output register. Depends on aws_pkg, aws_if, aws_ctrl and aws_datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// How to use this block:
// Input words arrive on in_i (sample, first) and results leave on out_o
// (smoothed), both valid/ready streams; a word moves when valid and ready
// are high at a rising clock edge.
// A word with first set passes through unchanged. Any other word is blended
// with the previous output using weight |c-p|/(|c|+|p|), rounded by adding
// one half and truncating toward zero, computed as one exact integer ratio.
// One word is worked on at a time. A first word goes from prepare straight to
// commit; a blended word passes through the prepare, two shared multiplier
// passes, sum and divider setup steps and the restoring divider, which
// produces one quotient bit per cycle over SAMPLE_BITS + 1 steps, before
// commit. The next word is accepted once the sequencer is back in idle.
// With a free output register, the result is loaded there at commit.
// The result is held in an output register; the block accepts the next word
// while a finished result still waits there, and stalls only at commit when
// the receiver has not yet taken the previous result.
// Reset (rst_ni low, asynchronous) empties the output register, returns the
// sequencer to idle and clears the previous output to zero.
module adaptive_weighted_smoother_top #(
  parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  aws_in_if.sink    in_i,
  aws_out_if.source out_o
);
  import aws_pkg::*;

  aws_cmd_t cmd;
  aws_sts_t sts;
  logic     out_free;
  logic     out_vld_q;
  logic signed [SAMPLE_BITS-1:0] out_data_q;
  logic signed [SAMPLE_BITS-1:0] result;

  // The output register can take a new word when empty or being drained.
  assign out_free = !out_vld_q || out_o.ready;

  aws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  aws_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .sample_i (in_i.sample),
    .first_i  (in_i.first),
    .result_o (result)
  );

  // Output register: loaded at commit, emptied when the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd.commit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.commit) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.smoothed = out_data_q;

  // Only one word is in flight, so the input is closed in the cycle after an acceptance.
  `AWS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_i.valid && in_i.ready,
                  !in_i.ready, "input accepted while a word is in flight")

endmodule

[rtl/aws_ctrl.sv]
// Sequencer of the smoother: steps one word through prepare, multiply, sum
// and divide, and commits it when the output register is free. Uses aws_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aws_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_free_i,
  input  aws_pkg::aws_sts_t sts_i,
  output aws_pkg::aws_cmd_t cmd_o
);
  import aws_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_MUL1  = 3'd2;
  localparam logic [2:0] ST_MUL2  = 3'd3;
  localparam logic [2:0] ST_SUM   = 3'd4;
  localparam logic [2:0] ST_DINIT = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PREP;
        end
      end
      ST_PREP: begin
        // A first word needs no blend and goes straight to commit.
        if (sts_i.first) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.prep = 1'b1;
          state_d    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul_a = 1'b1;
        state_d     = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_b = 1'b1;
        state_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `AWS_ASSERT_IMP(a_commit_free, clk_i, rst_ni, cmd_o.commit, out_free_i,
                  "commit issued while the output register is occupied")
  `AWS_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0(cmd_o),
              "more than one datapath command in a cycle")

endmodule

[rtl/aws_datapath.sv]
// Datapath of the smoother: operand preparation, one shared multiplier,
// numerator sum, restoring divider and result selection. Uses aws_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aws_datapath #(
  parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aws_pkg::aws_cmd_t             cmd_i,
  output aws_pkg::aws_sts_t             sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          first_i,
  output logic signed [SAMPLE_BITS-1:0] result_o
);
  import aws_pkg::*;

  localparam int N     = SAMPLE_BITS;
  localparam int PW    = 2 * N + 3;        // product width
  localparam int NUM_W = 2 * N + 4;        // numerator width
  localparam int K     = N + 1;            // quotient bits
  localparam int RW    = N + 2;            // remainder and divisor width
  localparam int CW    = $clog2(K);
  localparam logic [CW-1:0] LAST_STEP = CW'(K - 1);
  localparam logic signed [K:0] RMAX = (K + 1)'((2 ** (N - 1)) - 1);
  localparam logic signed [K:0] RMIN = -RMAX - (K + 1)'(1);

  logic signed [N-1:0]     c_q, p_q;
  logic                    first_q;
  logic        [N:0]       s_q;
  logic        [N-1:0]     dif_q;
  logic signed [N:0]       pc_q;
  logic signed [PW-1:0]    acc_q, prod_q;
  logic signed [NUM_W-1:0] num_q;
  logic        [RW-1:0]    rem_q, divisor_q;
  logic        [K-1:0]     qsh_q;
  logic                    neg_q;
  logic        [CW-1:0]    cnt_q;

  // Operand preparation.
  logic signed [N:0] c_ext, p_ext, abs_c, abs_p, pc_d, abs_pc;
  assign c_ext  = {c_q[N-1], c_q};
  assign p_ext  = {p_q[N-1], p_q};
  assign abs_c  = c_ext[N] ? -c_ext : c_ext;
  assign abs_p  = p_ext[N] ? -p_ext : p_ext;
  assign pc_d   = p_ext - c_ext;
  assign abs_pc = pc_d[N] ? -pc_d : pc_d;

  // Shared multiplier: c*S on the first pass, D*(p-c) on the second.
  logic signed [N:0]    mul_x;
  logic signed [N+1:0]  mul_y;
  logic signed [PW-1:0] mul_p;
  assign mul_x = cmd_i.mul_a ? c_ext : pc_q;
  assign mul_y = cmd_i.mul_a ? $signed({1'b0, s_q}) : $signed({2'b00, dif_q});
  assign mul_p = mul_x * mul_y;

  // Numerator 2*(c*S + D*(p-c)) + S.
  logic signed [NUM_W-1:0] t_sum, num_d, mag;
  assign t_sum = {acc_q[PW-1], acc_q} + {prod_q[PW-1], prod_q};
  assign num_d = {t_sum[NUM_W-2:0], 1'b0} + $signed({{(NUM_W-N-1){1'b0}}, s_q});
  assign mag   = num_q[NUM_W-1] ? -num_q : num_q;

  // One restoring division step.
  logic [RW:0]   trial, trial_sub;
  logic          ge;
  assign trial     = {rem_q, qsh_q[K-1]};
  assign trial_sub = trial - {1'b0, divisor_q};
  assign ge        = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q     <= sample_i;
      first_q <= first_i;
    end
    if (cmd_i.prep) begin
      s_q   <= abs_c + abs_p;
      dif_q <= abs_pc[N-1:0];
      pc_q  <= pc_d;
    end
    if (cmd_i.mul_a) begin
      prod_q <= mul_p;
    end
    if (cmd_i.mul_b) begin
      acc_q  <= prod_q;
      prod_q <= mul_p;
    end
    if (cmd_i.sum) begin
      num_q <= num_d;
    end
    if (cmd_i.div_init) begin
      rem_q     <= mag[K+RW-1:K];
      qsh_q     <= mag[K-1:0];
      divisor_q <= {s_q, 1'b0};
      neg_q     <= num_q[NUM_W-1];
      cnt_q     <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
      qsh_q <= {qsh_q[K-2:0], ge};
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // The previous output is model state and resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else if (cmd_i.commit) begin
      p_q <= result_o;
    end
  end

  // Signed quotient, clamped to the sample range.
  logic signed [K:0] q_s, r_s;
  assign q_s = $signed({1'b0, qsh_q});
  assign r_s = neg_q ? -q_s : q_s;

  always_comb begin
    if (first_q) begin
      result_o = c_q;
    end else if (s_q == '0) begin
      result_o = '0;
    end else if (r_s > RMAX) begin
      result_o = RMAX[N-1:0];
    end else if (r_s < RMIN) begin
      result_o = RMIN[N-1:0];
    end else begin
      result_o = r_s[N-1:0];
    end
  end

  assign sts_o.first    = first_q;
  assign sts_o.div_last = (cnt_q == LAST_STEP);

  `AWS_ASSERT_IMP(a_rem_bound, clk_i, rst_ni, cmd_i.div_step && (divisor_q != '0),
                  rem_q < divisor_q, "divider remainder not below divisor")

endmodule

[bench/aws_smooth_check.sv]
// Checker for the adaptive weighted smoother: watches both word streams,
// computes each smoothed value on its own and compares. Depends on aws_pkg.
`timescale 1ns / 1ps

module aws_smooth_check #(
  parameter int SAMPLE_BITS = aws_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_i,
  input  logic                          in_first_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0] out_smoothed_i,
  output int                            mismatch_count_o,
  output int                            pending_o
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam longint SmpMax = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SmpMin = -SmpMax - 1;

  sample_t prev_smoothed;
  sample_t smoothed_q[$];
  sample_t want;
  int      mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Exact rational blend: (2*(c*S + D*(p-c)) + S) / (2*S), truncated toward zero.
  function automatic sample_t blend_sample(sample_t cur, sample_t prev);
    longint c;
    longint p;
    longint mag_sum;
    longint diff_mag;
    longint num;
    longint r;
    c       = cur;
    p       = prev;
    mag_sum = (c < 0 ? -c : c) + (p < 0 ? -p : p);
    if (mag_sum == 0) begin
      return '0;
    end
    diff_mag = (c > p) ? c - p : p - c;
    num      = 2 * (c * mag_sum + diff_mag * (p - c)) + mag_sum;
    r        = num / (2 * mag_sum);
    if (r > SmpMax) r = SmpMax;
    if (r < SmpMin) r = SmpMin;
    return sample_t'(r);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] smoothed word error: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_smoothed = '0;
      smoothed_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        prev_smoothed = in_first_i ? in_sample_i : blend_sample(in_sample_i, prev_smoothed);
        smoothed_q.push_back(prev_smoothed);
      end
      if (out_valid_i && out_ready_i) begin
        if (smoothed_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", out_smoothed_i));
        end else begin
          want = smoothed_q.pop_front();
          if (out_smoothed_i !== want) begin
            report_mismatch($sformatf("expected %0d, got %0d", want, out_smoothed_i));
          end
        end
      end
    end
    pending_o = smoothed_q.size();
  end

endmodule

[bench/tb.sv]
// Top of the smoother testbench: clock, reset, stimulus, receiver stalls and
// the verdict. Depends on aws_pkg, aws_if, the RTL top and aws_smooth_check.
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLE_BITS   = aws_pkg::SAMPLE_BITS_DEF;
  localparam int RANDOM_WORDS  = 750;
  // Slowest correct run is roughly 800 words times (the work on a blended
  // word, the longest sender gap and the longest receiver stall); this is
  // several times that.
  localparam int CYCLE_LIMIT   = 400000;
  // Latency of a blended word plus the output register, with margin.
  localparam int DRAIN_CYCLES  = 40;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SmpMax = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SmpMin = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  int      cycles = 0;
  int      ready_hold = 0;
  int      mismatches;
  int      pending;
  bit      calm = 1'b0;
  sample_t last_sent = '0;

  aws_in_if  #(.W(SAMPLE_BITS)) in_ch  ();
  aws_out_if #(.W(SAMPLE_BITS)) out_ch ();

  adaptive_weighted_smoother_top #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // The checker sees both streams at the same edges as the block does and
  // reports how many mismatches it found and how many words it still awaits.
  aws_smooth_check #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) smooth_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_ch.valid),
    .in_ready_i      (in_ch.ready),
    .in_sample_i     (in_ch.sample),
    .in_first_i      (in_ch.first),
    .out_valid_i     (out_ch.valid),
    .out_ready_i     (out_ch.ready),
    .out_smoothed_i  (out_ch.smoothed),
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("adaptive_weighted_smoother_top test failed");
      $finish;
    end
  end

  // Receiver: ready is held for random stretches. Most stalls are short, a
  // few are long, and now and then ready stays high for a long run so that
  // back-to-back results are taken too.
  always @(posedge clk_i) begin
    int pick;
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        out_ch.ready <= 1'b1;
        ready_hold = $urandom_range(0, 8);
      end else if (pick < 90) begin
        out_ch.ready <= 1'b0;
        ready_hold = $urandom_range(0, 3);
      end else if (pick < 95) begin
        out_ch.ready <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end else begin
        out_ch.ready <= 1'b1;
        ready_hold = $urandom_range(50, 200);
      end
    end
  end

  // Sender gap after an accepted word. In calm stretches the sender never
  // idles, so words queue up behind the block's own busy time.
  function automatic int idle_gap();
    int pick;
    if (calm) begin
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Sample mix: plain random words cover every bit, while small values,
  // the extremes, values near the last one and its negation push the
  // blend weight toward zero, one and the rounding boundaries.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      4: begin
        return sample_t'(int'($urandom_range(0, 128)) - 64);
      end
      5: begin
        case ($urandom_range(0, 5))
          0: return SmpMax;
          1: return SmpMin;
          2: return SmpMax - sample_t'(1);
          3: return SmpMin + sample_t'(1);
          4: return sample_t'(1);
          default: return sample_t'(-1);
        endcase
      end
      6: begin
        return last_sent + sample_t'(int'($urandom_range(0, 32)) - 16);
      end
      7: begin
        return -last_sent;
      end
      default: begin
        return sample_t'($urandom);
      end
    endcase
  endfunction

  // Offers one word and returns once it has been accepted, then idles for
  // a random gap. Valid stays high when no gap follows.
  task automatic send_word(sample_t smp, bit first_flag);
    int gap;
    in_ch.valid  <= 1'b1;
    in_ch.sample <= smp;
    in_ch.first  <= first_flag;
    last_sent = smp;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the sender off until every word sent so far has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int run_left;
    bit first_flag;
    run_left = 0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.first  = 1'b0;
    out_ch.ready = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The first two words come before any first-flagged word:
    // both values zero, then a blend against the previous output of zero.
    send_word(sample_t'(0), 1'b0);
    send_word(sample_t'(100), 1'b0);
    send_word(SmpMin, 1'b1);
    send_word(SmpMax, 1'b0);
    send_word(SmpMin, 1'b0);
    send_word(SmpMax, 1'b1);
    send_word(SmpMax, 1'b0);
    send_word(sample_t'(0), 1'b1);
    send_word(sample_t'(0), 1'b0);
    send_word(sample_t'(-1), 1'b0);
    send_word(sample_t'(1), 1'b0);
    send_word(SmpMin, 1'b1);
    send_word(SmpMin, 1'b0);
    send_word(sample_t'(0), 1'b0);
    send_word(sample_t'(12345), 1'b0);
    send_word(sample_t'(-12345), 1'b0);
    send_word(SmpMin + sample_t'(1), 1'b0);
    send_word(SmpMax, 1'b0);
    send_word(sample_t'(-1), 1'b1);
    send_word(sample_t'(1), 1'b0);
    send_word(sample_t'(3), 1'b0);

    // The sender waits here until the block has handed back every word.
    drain_results();

    // Random part: runs of blended words, most of them opened by a first
    // word, a few not, and an odd first word dropped into the middle.
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 60 == 0) begin
        calm = ($urandom_range(0, 2) == 0);
      end
      if (i == RANDOM_WORDS / 2) begin
        drain_results();
      end
      if (run_left == 0) begin
        first_flag = ($urandom_range(0, 9) != 0);
        run_left = $urandom_range(1, 24);
      end else begin
        first_flag = ($urandom_range(0, 29) == 0);
        run_left--;
      end
      send_word(pick_sample(), first_flag);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("adaptive_weighted_smoother_top test passed");
    end else begin
      $display("adaptive_weighted_smoother_top test failed");
    end
    $finish;
  end

endmodule
